// ----- design/pose_settle_detector_top_defines.svh -----
// Assertion macros shared by the checker of the pose settle detector.
// The including module must provide clk and rst_n, and out_valid for the
// result-side macro.
`ifndef POSE_SETTLE_DETECTOR_TOP_DEFINES_SVH
`define POSE_SETTLE_DETECTOR_TOP_DEFINES_SVH

// General clocked assertion, switched off while reset is asserted.
`define PSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the contents of a result that is being offered.
`define PSD_ASSERT_RESULT(label, cond, msg) \
    `PSD_ASSERT(label, out_valid |-> (cond), msg)

`endif

// ----- design/psd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    // Field widths
    localparam int POS_W      = 24;
    localparam int HEAD_W     = 16;
    localparam int STAMP_W    = 48;
    localparam int AGE_W      = 32;
    localparam int SETTLE_W   = 32;
    localparam int LIMIT_W    = 24;
    localparam int LIM2_W     = 2 * LIMIT_W;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int TURN_W     = HEAD_W + 1;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD_LIMIT  = 3'd4;

    // Register reset values
    localparam logic [STAMP_W-1:0]  BASELINE_RESET    = '0;
    localparam logic [AGE_W-1:0]    MAX_AGE_RESET     = 32'd1000000;
    localparam logic [SETTLE_W-1:0] SETTLE_RESET      = 32'd1000000;
    localparam logic [LIMIT_W-1:0]  TRANS_LIMIT_RESET = 24'd50;
    localparam logic [LIM2_W-1:0]   LIM2_RESET        =
        LIM2_W'(TRANS_LIMIT_RESET) * LIM2_W'(TRANS_LIMIT_RESET);
    localparam logic [HEAD_W-1:0]   HEAD_LIMIT_RESET  = 16'd364;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INVALID      = 3'd0,
        ST_STALE        = 3'd1,
        ST_PRE_BASELINE = 3'd2,
        ST_DUPLICATE    = 3'd3,
        ST_FIRST_ANCHOR = 3'd4,
        ST_SETTLING     = 3'd5,
        ST_PROVEN       = 3'd6,
        ST_WAITING      = 3'd7
    } status_t;

    // One pose sample as held in the input register
    typedef struct packed {
        logic signed [POS_W-1:0] pos_x_mm;
        logic signed [POS_W-1:0] pos_y_mm;
        logic [HEAD_W-1:0]       heading;
        logic [STAMP_W-1:0]      sample_stamp_us;
        logic signed [AGE_W-1:0] sample_age_us;
        logic [STAMP_W-1:0]      observed_at_us;
        logic                    sample_valid;
    } sample_t;

    // Current register settings; the translation limit is kept squared
    typedef struct packed {
        logic [STAMP_W-1:0]  baseline_stamp_us;
        logic [AGE_W-1:0]    max_age_us;
        logic [SETTLE_W-1:0] settle_us;
        logic [LIM2_W-1:0]   trans_limit_sq;
        logic [HEAD_W-1:0]   heading_limit;
    } cfg_t;

    // Tracker clear request raised by a baseline write
    typedef struct packed {
        logic               clear;
        logic [STAMP_W-1:0] stamp;
    } clear_t;

    // One result
    typedef struct packed {
        logic    pose_ready;
        status_t status_code;
    } result_t;

endpackage

`default_nettype wire

// ----- design/psd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pose sample channel
interface pose_sample_if;
    import psd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x_mm;
    logic signed [POS_W-1:0] pos_y_mm;
    logic [HEAD_W-1:0]       heading;
    logic [STAMP_W-1:0]      sample_stamp_us;
    logic signed [AGE_W-1:0] sample_age_us;
    logic [STAMP_W-1:0]      observed_at_us;
    logic                    sample_valid;

    modport source (
        output valid, pos_x_mm, pos_y_mm, heading, sample_stamp_us,
               sample_age_us, observed_at_us, sample_valid,
        input  ready
    );

    modport sink (
        input  valid, pos_x_mm, pos_y_mm, heading, sample_stamp_us,
               sample_age_us, observed_at_us, sample_valid,
        output ready
    );
endinterface

// Result channel
interface pose_result_if;
    import psd_pkg::*;

    logic                valid;
    logic                ready;
    logic                pose_ready;
    logic [STATUS_W-1:0] status_code;

    modport source (
        output valid, pose_ready, status_code,
        input  ready
    );

    modport sink (
        input  valid, pose_ready, status_code,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/psd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [psd_pkg::CFG_IDX_W-1:0]   index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  data,
    output psd_pkg::cfg_t                   cfg,
    output psd_pkg::clear_t                 clr
);
    import psd_pkg::*;

    logic [STAMP_W-1:0]  baseline_reg;
    logic [AGE_W-1:0]    max_age_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic [LIM2_W-1:0]   lim2_reg;
    logic [HEAD_W-1:0]   head_limit_reg;
    logic [LIMIT_W-1:0]  limit_wr;
    logic [LIM2_W-1:0]   lim2_next;

    // The translation limit is squared once, when it is written.
    assign limit_wr  = data[LIMIT_W-1:0];
    assign lim2_next = LIM2_W'(limit_wr) * LIM2_W'(limit_wr);

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg   <= BASELINE_RESET;
            max_age_reg    <= MAX_AGE_RESET;
            settle_reg     <= SETTLE_RESET;
            lim2_reg       <= LIM2_RESET;
            head_limit_reg <= HEAD_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_BASELINE:    baseline_reg   <= data[STAMP_W-1:0];
                REG_MAX_AGE:     max_age_reg    <= data[AGE_W-1:0];
                REG_SETTLE:      settle_reg     <= data[SETTLE_W-1:0];
                REG_TRANS_LIMIT: lim2_reg       <= lim2_next;
                REG_HEAD_LIMIT:  head_limit_reg <= data[HEAD_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.baseline_stamp_us = baseline_reg;
    assign cfg.max_age_us        = max_age_reg;
    assign cfg.settle_us         = settle_reg;
    assign cfg.trans_limit_sq    = lim2_reg;
    assign cfg.heading_limit     = head_limit_reg;

    // A baseline write restarts the tracker from the new stamp.
    assign clr.clear = wr_en && (index == REG_BASELINE);
    assign clr.stamp = data[STAMP_W-1:0];

endmodule

`default_nettype wire

// ----- design/psd_track.sv -----
`timescale 1ns / 1ps
`default_nettype none

module psd_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  psd_pkg::sample_t  smp,
    input  psd_pkg::cfg_t     cfg,
    input  psd_pkg::clear_t   clr,
    output psd_pkg::result_t  res
);
    import psd_pkg::*;

    logic [STAMP_W-1:0]      last_stamp_reg, last_stamp_next;
    logic signed [POS_W-1:0] anchor_x_reg, anchor_x_next;
    logic signed [POS_W-1:0] anchor_y_reg, anchor_y_next;
    logic [HEAD_W-1:0]       anchor_head_reg, anchor_head_next;
    logic [STAMP_W-1:0]      settle_start_reg, settle_start_next;
    logic                    anchor_present_reg, anchor_present_next;
    logic                    ready_flag_reg, ready_flag_next;

    logic [AGE_W-1:0]         age_u;
    logic                     stale;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [SQ_W-1:0]   dx_sq;
    logic signed [SQ_W-1:0]   dy_sq;
    logic [DIST_W-1:0]        dist_sq;
    logic [HEAD_W-1:0]        dh;
    logic [TURN_W-1:0]        turn;
    logic                     moved;
    logic [STAMP_W-1:0]       elapsed;
    logic                     settled;
    logic                     ready;
    status_t                  status;

    // Freshness: a negative age is stale as well as one above the limit.
    assign age_u = unsigned'(smp.sample_age_us);
    assign stale = age_u[AGE_W-1] || (age_u > cfg.max_age_us);

    // Squared distance from the anchor.
    assign dx      = DIFF_W'(smp.pos_x_mm) - DIFF_W'(anchor_x_reg);
    assign dy      = DIFF_W'(smp.pos_y_mm) - DIFF_W'(anchor_y_reg);
    assign dx_sq   = dx * dx;
    assign dy_sq   = dy * dy;
    assign dist_sq = DIST_W'(unsigned'(dx_sq)) + DIST_W'(unsigned'(dy_sq));

    // Heading change wrapped to half a turn either way.
    assign dh   = smp.heading - anchor_head_reg;
    assign turn = dh[HEAD_W-1] ? ((TURN_W'(1) << HEAD_W) - TURN_W'(dh)) : TURN_W'(dh);

    assign moved = (dist_sq > DIST_W'(cfg.trans_limit_sq))
                || (turn > TURN_W'(cfg.heading_limit));

    // Settle test; an observation before the anchor time never settles.
    assign elapsed = smp.observed_at_us - settle_start_reg;
    assign settled = (smp.observed_at_us >= settle_start_reg)
                  && (elapsed >= STAMP_W'(cfg.settle_us));

    // Classification and next tracker state
    always_comb
    begin
        last_stamp_next     = last_stamp_reg;
        anchor_x_next       = anchor_x_reg;
        anchor_y_next       = anchor_y_reg;
        anchor_head_next    = anchor_head_reg;
        settle_start_next   = settle_start_reg;
        anchor_present_next = anchor_present_reg;
        ready_flag_next     = ready_flag_reg;
        ready               = 1'b0;
        status              = ST_INVALID;

        priority if (!smp.sample_valid || (cfg.max_age_us == '0))
        begin
            status = ST_INVALID;
        end
        else if (stale)
        begin
            status = ST_STALE;
        end
        else if (smp.sample_stamp_us <= cfg.baseline_stamp_us)
        begin
            status = ST_PRE_BASELINE;
        end
        else if (smp.sample_stamp_us <= last_stamp_reg)
        begin
            status = ST_DUPLICATE;
            ready  = ready_flag_reg;
        end
        else
        begin
            last_stamp_next = smp.sample_stamp_us;
            priority if (!anchor_present_reg || moved)
            begin
                anchor_x_next     = smp.pos_x_mm;
                anchor_y_next     = smp.pos_y_mm;
                anchor_head_next  = smp.heading;
                settle_start_next = smp.observed_at_us;
                if (!anchor_present_reg)
                begin
                    anchor_present_next = 1'b1;
                    status              = ST_FIRST_ANCHOR;
                end
                else
                begin
                    ready_flag_next = 1'b0;
                    status          = ST_SETTLING;
                end
            end
            else
            begin
                ready_flag_next = settled;
                ready           = settled;
                status          = settled ? ST_PROVEN : ST_WAITING;
            end
        end
    end

    assign res.pose_ready  = ready;
    assign res.status_code = status;

    // Tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg     <= BASELINE_RESET;
            anchor_x_reg       <= '0;
            anchor_y_reg       <= '0;
            anchor_head_reg    <= '0;
            settle_start_reg   <= '0;
            anchor_present_reg <= 1'b0;
            ready_flag_reg     <= 1'b0;
        end
        else if (clr.clear)
        begin
            last_stamp_reg     <= clr.stamp;
            anchor_x_reg       <= '0;
            anchor_y_reg       <= '0;
            anchor_head_reg    <= '0;
            settle_start_reg   <= '0;
            anchor_present_reg <= 1'b0;
            ready_flag_reg     <= 1'b0;
        end
        else if (fire)
        begin
            last_stamp_reg     <= last_stamp_next;
            anchor_x_reg       <= anchor_x_next;
            anchor_y_reg       <= anchor_y_next;
            anchor_head_reg    <= anchor_head_next;
            settle_start_reg   <= settle_start_next;
            anchor_present_reg <= anchor_present_next;
            ready_flag_reg     <= ready_flag_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/pose_settle_detector_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pose settle detector. Takes one pose sample per clock while ready is not
// held off, and returns one result per sample, in order: a ready flag and a
// status code. A sample is captured in an input register on acceptance and
// its result is loaded into the output register once that register is free
// or emptying, and is offered from there. While a result waits, the input
// register still takes one more request and then holds off the input.
// The cycle time is set by the anchor comparison, two 25 by 25 bit squarers
// and a 51 bit add and compare, which cannot be split across registers
// because each sample may move the anchor used by the next. Write the
// configuration registers only while no sample is in flight; a baseline write
// also clears the anchor and the ready flag.
module pose_settle_detector_top (
    input  logic                            clk,
    input  logic                            rst_n,
    pose_sample_if.sink                     sample,
    pose_result_if.source                   result,
    input  logic                            cfg_wr_en,
    input  logic [psd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import psd_pkg::*;

    cfg_t    cfg;
    clear_t  clr;
    sample_t sample_in;
    sample_t in_data_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_data_reg;
    logic    out_valid_reg;
    logic    advance;

    psd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg),
        .clr   (clr)
    );

    psd_track u_track (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .smp   (in_data_reg),
        .cfg   (cfg),
        .clr   (clr),
        .res   (res)
    );

    // Gather the request payload.
    assign sample_in.pos_x_mm        = sample.pos_x_mm;
    assign sample_in.pos_y_mm        = sample.pos_y_mm;
    assign sample_in.heading         = sample.heading;
    assign sample_in.sample_stamp_us = sample.sample_stamp_us;
    assign sample_in.sample_age_us   = sample.sample_age_us;
    assign sample_in.observed_at_us  = sample.observed_at_us;
    assign sample_in.sample_valid    = sample.sample_valid;

    // The held sample moves on when the output register is free or emptying.
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_data_reg <= sample_in;
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pose_ready  = out_data_reg.pose_ready;
    assign result.status_code = out_data_reg.status_code;

endmodule

`default_nettype wire

// ----- design/psd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "pose_settle_detector_top_defines.svh"

module psd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           pose_ready,
    input  logic [psd_pkg::STATUS_W-1:0]   status_code
);
    import psd_pkg::*;

    // Ready may only accompany a proven pose or a repeated duplicate.
    `PSD_ASSERT_RESULT(a_ready_status, !pose_ready || (status_code == ST_PROVEN) || (status_code == ST_DUPLICATE), "pose_ready set with a status that cannot carry it")

    // A proven status always reports ready.
    `PSD_ASSERT_RESULT(a_proven_ready, (status_code != ST_PROVEN) || pose_ready, "proven status without pose_ready")

    // A stalled result keeps its contents.
    `PSD_ASSERT(a_result_hold, out_valid && !out_ready |=> out_valid && $stable(pose_ready) && $stable(status_code), "stalled result changed")

    // A result appearing on an empty output follows an accepted request that passed through the input register.
    `PSD_ASSERT(a_result_origin, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a matching request")

endmodule

bind pose_settle_detector_top psd_checker u_psd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .pose_ready  (result.pose_ready),
    .status_code (result.status_code)
);

`default_nettype wire
